FILE: rtl/core/tpdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpdf_pkg
// Shared types and constants for the touch point delay filter.
// ----------------------------------------------------------------------------
package tpdf_pkg;

	localparam int unsigned CMD_W      = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IDLE_W     = 16;
	localparam int unsigned SKIP_W     = 4;
	localparam int unsigned TAIL_W     = 5;

	localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST  = 16'd60;
	localparam logic [SKIP_W-1:0] HEADER_SKIP_RST = 4'd4;
	localparam logic [TAIL_W-1:0] TAIL_DELAY_RST  = 5'd6;

	typedef enum logic [CMD_W-1:0] {
		CMD_X_AXIS     = 3'd0,
		CMD_Y_AXIS     = 3'd1,
		CMD_OTHER_AXIS = 3'd2,
		CMD_TOUCH_KEY  = 3'd3,
		CMD_OTHER_KEY  = 3'd4,
		CMD_OTHER_TYPE = 3'd5,
		CMD_IDLE_TICK  = 3'd6
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IDLE_LIMIT  = 2'd0,
		CFG_HEADER_SKIP = 2'd1,
		CFG_TAIL_DELAY  = 2'd2
	} cfg_idx_t;

endpackage
`default_nettype wire

FILE: rtl/core/tpdf_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpdf_ring
// Point ring: separate x and y halves, one write port, one registered read.
// ----------------------------------------------------------------------------
module tpdf_ring #(
	parameter int DEPTH  = 32,
	parameter int DATA_W = 12
) (
	input  wire logic                     clk,
	input  wire logic                     x_we,
	input  wire logic                     y_we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [DATA_W-1:0]        rd_x,
	output      logic [DATA_W-1:0]        rd_y
);

	logic [DATA_W-1:0] x_mem [DEPTH];
	logic [DATA_W-1:0] y_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[wr_addr] <= wr_data;
		end
		if (y_we) begin
			y_mem[wr_addr] <= wr_data;
		end
	end

	// read returns contents before this edge's write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_x <= x_mem[rd_addr];
			rd_y <= y_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/touch_point_delay_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_point_delay_filter_unit
// Turns touch controller events into delayed press/release pointer reports.
// ----------------------------------------------------------------------------
// Every accepted event produces exactly one result, presented in the next
// cycle, and a new event can be taken every cycle unless the output stalls.
// The state update for an event is done in the cycle it is accepted; the
// delayed point is read from the point ring through its registered read port.
// The result register stalls with the output; the input is ready whenever
// the result register is empty or being drained. The ring needs no clearing
// after reset; only points of the current stroke are ever reported.
module touch_point_delay_filter_unit
	import tpdf_pkg::*;
#(
	parameter int RING_DEPTH = 32,
	parameter int COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// [2:0] command, [COORD_BITS+2:3] coord_value, rest zero
	input  wire logic [((CMD_W+COORD_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic s_tvalid,
	output      logic s_tready,
	// [0] report_valid, [1] pressed, point_x, point_y, backlight_on, rest zero
	output      logic [((2*COORD_BITS+3+7)/8)*8-1:0] m_tdata,
	output      logic m_tvalid,
	input  wire logic m_tready,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW        = $clog2(RING_DEPTH);
	localparam int HW        = $clog2(RING_DEPTH + 1);
	localparam int CMPW      = (HW > TAIL_W) ? HW : TAIL_W;
	localparam int OUT_RAW   = 2 * COORD_BITS + 3;
	localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8;
	localparam int RED_STEPS = ((1 << TAIL_W) - 1) / RING_DEPTH;

	// configuration
	logic [IDLE_W-1:0] idle_limit_q;
	logic [SKIP_W-1:0] header_skip_q;
	logic [TAIL_W-1:0] tail_delay_q;

	// tracking state
	logic [AW-1:0]     wi_q;
	logic [HW-1:0]     held_q;
	logic [SKIP_W-1:0] skip_q;
	logic              x_seen_q;
	logic              light_q;
	logic [IDLE_W-1:0] idle_q;

	// result stage
	logic                  valid_s1;
	logic                  rpt_s1;
	logic                  press_s1;
	logic                  light_s1;
	logic                  byp_s1;
	logic [COORD_BITS-1:0] byp_y_s1;

	logic [COORD_BITS-1:0] rd_x;
	logic [COORD_BITS-1:0] rd_y;

	cmd_t                  cmd;
	logic [COORD_BITS-1:0] coord;
	logic                  accept;

	logic [CMPW-1:0]   back_w;
	logic [AW:0]       slot_sum;
	logic [AW-1:0]     slot;
	logic [AW-1:0]     wi_inc;
	logic [HW-1:0]     held_inc;
	logic [IDLE_W-1:0] idle_inc;

	logic              x_we;
	logic              y_we;
	logic              rpt_d;
	logic              press_d;
	logic              end_stroke;
	logic [AW-1:0]     wi_d;
	logic [HW-1:0]     held_d;
	logic [SKIP_W-1:0] skip_d;
	logic              x_seen_d;
	logic              light_d;
	logic [IDLE_W-1:0] idle_d;

	assign cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
	assign coord    = s_tdata[CMD_W+COORD_BITS-1:CMD_W];
	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	// tail delay modulo ring depth, then the slot that many entries back
	always_comb begin
		back_w = CMPW'(tail_delay_q);
		for (int i = 0; i < RED_STEPS; i++) begin
			if (back_w >= CMPW'(RING_DEPTH)) begin
				back_w = back_w - CMPW'(RING_DEPTH);
			end
		end
		slot_sum = {1'b0, wi_q} + (AW+1)'(RING_DEPTH) - {1'b0, back_w[AW-1:0]};
		if (slot_sum >= (AW+1)'(RING_DEPTH)) begin
			slot_sum = slot_sum - (AW+1)'(RING_DEPTH);
		end
		slot = slot_sum[AW-1:0];
	end

	assign wi_inc   = (wi_q == AW'(RING_DEPTH - 1)) ? '0 : wi_q + 1'b1;
	assign held_inc = (held_q < HW'(RING_DEPTH)) ? held_q + 1'b1 : held_q;
	assign idle_inc = (idle_q != '1) ? idle_q + 1'b1 : idle_q;

	always_comb begin
		x_we       = 1'b0;
		y_we       = 1'b0;
		rpt_d      = 1'b0;
		press_d    = 1'b0;
		end_stroke = 1'b0;
		wi_d       = wi_q;
		held_d     = held_q;
		skip_d     = skip_q;
		x_seen_d   = x_seen_q;
		light_d    = light_q;
		idle_d     = idle_q;
		case (cmd)
			CMD_X_AXIS: begin
				x_we     = 1'b1;
				x_seen_d = 1'b1;
			end
			CMD_Y_AXIS: begin
				if (x_seen_q) begin
					y_we = 1'b1;
					if (skip_q != '0) begin
						skip_d = skip_q - 1'b1;
					end else begin
						held_d = held_inc;
						wi_d   = wi_inc;
						if (CMPW'(held_inc) > CMPW'(tail_delay_q) && light_q) begin
							rpt_d   = 1'b1;
							press_d = 1'b1;
						end
					end
				end
				x_seen_d = 1'b0;
			end
			CMD_TOUCH_KEY: begin
				light_d    = 1'b1;
				idle_d     = '0;
				rpt_d      = CMPW'(held_q) > CMPW'(tail_delay_q);
				end_stroke = 1'b1;
			end
			CMD_OTHER_KEY: begin
				end_stroke = 1'b1;
			end
			CMD_IDLE_TICK: begin
				idle_d = idle_inc;
				if (idle_inc > idle_limit_q) begin
					light_d = 1'b0;
				end
			end
			default: begin
				x_seen_d = 1'b0;
			end
		endcase
		if (end_stroke) begin
			held_d   = '0;
			wi_d     = '0;
			skip_d   = header_skip_q;
			x_seen_d = 1'b0;
		end
	end

	tpdf_ring #(
		.DEPTH  (RING_DEPTH),
		.DATA_W (COORD_BITS)
	) u_ring (
		.clk     (clk),
		.x_we    (accept && x_we),
		.y_we    (accept && y_we),
		.wr_addr (wi_q),
		.wr_data (coord),
		.rd_en   (accept),
		.rd_addr (slot),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q  <= IDLE_LIMIT_RST;
			header_skip_q <= HEADER_SKIP_RST;
			tail_delay_q  <= TAIL_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IDLE_LIMIT:  idle_limit_q  <= cfg_wdata[IDLE_W-1:0];
				CFG_HEADER_SKIP: header_skip_q <= cfg_wdata[SKIP_W-1:0];
				CFG_TAIL_DELAY:  tail_delay_q  <= cfg_wdata[TAIL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q     <= '0;
			held_q   <= '0;
			skip_q   <= HEADER_SKIP_RST;
			x_seen_q <= 1'b0;
			light_q  <= 1'b1;
			idle_q   <= '0;
		end else if (accept) begin
			wi_q     <= wi_d;
			held_q   <= held_d;
			skip_q   <= skip_d;
			x_seen_q <= x_seen_d;
			light_q  <= light_d;
			idle_q   <= idle_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// forward the y half when the delayed slot is the one written this cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rpt_s1   <= rpt_d;
			press_s1 <= press_d;
			light_s1 <= light_d;
			byp_s1   <= y_we && (slot == wi_q);
			byp_y_s1 <= coord;
		end
	end

	logic [COORD_BITS-1:0] px;
	logic [COORD_BITS-1:0] py;

	assign px       = rpt_s1 ? rd_x : '0;
	assign py       = !rpt_s1 ? '0 : (byp_s1 ? byp_y_s1 : rd_y);
	assign m_tvalid = valid_s1;
	assign m_tdata  = OUT_W'({light_s1, py, px, rpt_s1 && press_s1, rpt_s1});

	a_press_needs_light: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] && m_tdata[1] |-> m_tdata[OUT_RAW-1])
		else $error("press reported with backlight off");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(RING_DEPTH))
		else $error("held count beyond ring depth");

	a_touch_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_TOUCH_KEY |=> light_q && idle_q == '0 && held_q == '0)
		else $error("touch key did not wake backlight or end stroke");

	a_wi_range: assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= AW'(RING_DEPTH - 1))
		else $error("write index outside ring");

endmodule
`default_nettype wire
